>>> rtl/core/dgc_pkg.sv
// Package for the diploid genotype caller: shared types, register indexes
// and register reset values. Used by every module under rtl/core; it
// depends on nothing.
package dgc_pkg;

    // Width of the log-likelihood registers in signed fixed point.
    localparam int LOG_BITS   = 24;
    // Width of the coverage limit register.
    localparam int LIMIT_BITS = 8;
    // Configuration port widths.
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOG_ERROR_THIRD      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOG_NO_ERROR         = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOG_HALF_MINUS_ERROR = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOG_HETERO_PRIOR     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COVERAGE_LIMIT       = 3'd4;

    // Reset values, scaled for 16 fractional bits.
    localparam logic signed [LOG_BITS-1:0] RST_LOG_ERROR_THIRD      = -24'sd373801;
    localparam logic signed [LOG_BITS-1:0] RST_LOG_NO_ERROR         = -24'sd659;
    localparam logic signed [LOG_BITS-1:0] RST_LOG_HALF_MINUS_ERROR = -24'sd45864;
    localparam logic signed [LOG_BITS-1:0] RST_LOG_HETERO_PRIOR     = -24'sd452706;
    localparam logic [LIMIT_BITS-1:0]      RST_COVERAGE_LIMIT       = 8'd9;

    typedef logic [1:0] base_t;
    typedef logic signed [LOG_BITS-1:0] log_t;

    // One genotype call.
    typedef struct packed {
        logic  called;
        base_t first_allele;
        base_t second_allele;
    } call_t;

    // Decision flags carried from the likelihood stage to the decision stage.
    typedef struct packed {
        logic  cov_zero;
        logic  cov_low;
        logic  top_eq_second;
        logic  second_eq_third;
        call_t low_call;
        base_t top_base;
        base_t second_base;
    } call_flags_t;

endpackage

>>> rtl/core/dgc_sort.sv
// Sort stage of the genotype caller: orders the four base counts ascending,
// ties in base order, and sums the coverage. Registered output.
// Depends on dgc_pkg.
module dgc_sort #(
    parameter int COUNT_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    enable,
    input  logic [COUNT_BITS-1:0]   count_in [4],
    input  dgc_pkg::base_t          pooled_top_in,
    input  dgc_pkg::base_t          pooled_second_in,
    output logic [COUNT_BITS-1:0]   sorted_count_reg [4],
    output dgc_pkg::base_t          sorted_base_reg [4],
    output logic [COUNT_BITS+1:0]   coverage_reg,
    output dgc_pkg::base_t          pooled_top_reg,
    output dgc_pkg::base_t          pooled_second_reg
);

    localparam int COV_BITS = COUNT_BITS + 2;

    logic [COUNT_BITS-1:0] sorted_count_next [4];
    dgc_pkg::base_t        sorted_base_next [4];
    logic [COV_BITS-1:0]   coverage_next;

    // True when the key (count, base) at a sorts after the key at b.
    function automatic logic key_after(input logic [COUNT_BITS-1:0] ca,
                                       input dgc_pkg::base_t ba,
                                       input logic [COUNT_BITS-1:0] cb,
                                       input dgc_pkg::base_t bb);
        return (ca > cb) || ((ca == cb) && (ba > bb));
    endfunction

    // Five compare-exchange steps form a complete sorting network for four keys.
    // Keys include the base, so they are unique and the order is stable.
    always_comb begin
        logic [COUNT_BITS-1:0] c [4];
        dgc_pkg::base_t        b [4];
        logic [COUNT_BITS-1:0] ct;
        dgc_pkg::base_t        bt;
        ct = '0;
        bt = '0;
        for (int i = 0; i < 4; i++) begin
            c[i] = count_in[i];
            b[i] = dgc_pkg::base_t'(i);
        end
        if (key_after(c[0], b[0], c[1], b[1])) begin
            ct = c[0]; c[0] = c[1]; c[1] = ct;
            bt = b[0]; b[0] = b[1]; b[1] = bt;
        end
        if (key_after(c[2], b[2], c[3], b[3])) begin
            ct = c[2]; c[2] = c[3]; c[3] = ct;
            bt = b[2]; b[2] = b[3]; b[3] = bt;
        end
        if (key_after(c[0], b[0], c[2], b[2])) begin
            ct = c[0]; c[0] = c[2]; c[2] = ct;
            bt = b[0]; b[0] = b[2]; b[2] = bt;
        end
        if (key_after(c[1], b[1], c[3], b[3])) begin
            ct = c[1]; c[1] = c[3]; c[3] = ct;
            bt = b[1]; b[1] = b[3]; b[3] = bt;
        end
        if (key_after(c[1], b[1], c[2], b[2])) begin
            ct = c[1]; c[1] = c[2]; c[2] = ct;
            bt = b[1]; b[1] = b[2]; b[2] = bt;
        end
        for (int i = 0; i < 4; i++) begin
            sorted_count_next[i] = c[i];
            sorted_base_next[i]  = b[i];
        end
    end

    // Total coverage over the four bases.
    assign coverage_next = COV_BITS'(count_in[0]) + COV_BITS'(count_in[1])
                         + COV_BITS'(count_in[2]) + COV_BITS'(count_in[3]);

    // Stage register; payload only, no reset needed.
    always_ff @(posedge aclk) begin
        if (enable) begin
            sorted_count_reg  <= sorted_count_next;
            sorted_base_reg   <= sorted_base_next;
            coverage_reg      <= coverage_next;
            pooled_top_reg    <= pooled_top_in;
            pooled_second_reg <= pooled_second_in;
        end
    end

endmodule

>>> rtl/core/dgc_likelihood.sv
// Likelihood stage of the genotype caller: forms the four log-likelihood
// products and evaluates the low-coverage rule. Registered output.
// Depends on dgc_pkg.
module dgc_likelihood #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                      aclk,
    input  logic                                      enable,
    input  logic [COUNT_BITS-1:0]                     sorted_count [4],
    input  dgc_pkg::base_t                            sorted_base [4],
    input  logic [COUNT_BITS+1:0]                     coverage,
    input  dgc_pkg::base_t                            pooled_top,
    input  dgc_pkg::base_t                            pooled_second,
    input  dgc_pkg::log_t                             log_error_third,
    input  dgc_pkg::log_t                             log_no_error,
    input  dgc_pkg::log_t                             log_half_minus_error,
    input  logic [dgc_pkg::LIMIT_BITS-1:0]            coverage_limit,
    output logic signed [COUNT_BITS+2+dgc_pkg::LOG_BITS:0] homo_match_reg,
    output logic signed [COUNT_BITS+2+dgc_pkg::LOG_BITS:0] homo_error_reg,
    output logic signed [COUNT_BITS+2+dgc_pkg::LOG_BITS:0] het_match_reg,
    output logic signed [COUNT_BITS+2+dgc_pkg::LOG_BITS:0] het_error_reg,
    output dgc_pkg::call_flags_t                      flags_reg
);

    localparam int COV_BITS  = COUNT_BITS + 2;
    localparam int PROD_BITS = COV_BITS + 1 + dgc_pkg::LOG_BITS;

    logic [COV_BITS-1:0]         c0, c1, c2, c3;
    logic [COV_BITS-1:0]         cov_rest;
    logic [COV_BITS-1:0]         top_pair;
    logic [COV_BITS-1:0]         low_pair;
    logic [COV_BITS-1:0]         limit_ext;
    logic                        top_pooled;
    logic                        second_pooled;
    logic signed [PROD_BITS-1:0] homo_match_next;
    logic signed [PROD_BITS-1:0] homo_error_next;
    logic signed [PROD_BITS-1:0] het_match_next;
    logic signed [PROD_BITS-1:0] het_error_next;
    dgc_pkg::call_flags_t        flags_next;

    // Sorted counts widened to coverage width, and the count sums.
    assign c0        = COV_BITS'(sorted_count[0]);
    assign c1        = COV_BITS'(sorted_count[1]);
    assign c2        = COV_BITS'(sorted_count[2]);
    assign c3        = COV_BITS'(sorted_count[3]);
    assign cov_rest  = coverage - c3;
    assign top_pair  = c2 + c3;
    assign low_pair  = c0 + c1;
    assign limit_ext = COV_BITS'(coverage_limit);

    // One signed multiplier per term; operands are non-negative counts.
    assign homo_match_next = PROD_BITS'($signed({1'b0, c3}))
                           * PROD_BITS'(log_no_error);
    assign homo_error_next = PROD_BITS'($signed({1'b0, cov_rest}))
                           * PROD_BITS'(log_error_third);
    assign het_match_next  = PROD_BITS'($signed({1'b0, top_pair}))
                           * PROD_BITS'(log_half_minus_error);
    assign het_error_next  = PROD_BITS'($signed({1'b0, low_pair}))
                           * PROD_BITS'(log_error_third);

    // Pooled membership of the top two sorted bases.
    assign top_pooled    = (sorted_base[3] == pooled_top) || (sorted_base[3] == pooled_second);
    assign second_pooled = (sorted_base[2] == pooled_top) || (sorted_base[2] == pooled_second);

    // Low-coverage rule and the tie flags used by the likelihood comparison.
    always_comb begin
        flags_next                 = '0;
        flags_next.cov_zero        = (coverage == '0);
        flags_next.cov_low         = (coverage < limit_ext);
        flags_next.top_eq_second   = (c3 == c2);
        flags_next.second_eq_third = (c2 == c1);
        flags_next.top_base        = sorted_base[3];
        flags_next.second_base     = sorted_base[2];
        priority if (c3 + COV_BITS'(1) >= coverage) begin
            flags_next.low_call.called        = 1'b1;
            flags_next.low_call.first_allele  = sorted_base[3];
            flags_next.low_call.second_allele = sorted_base[3];
        end else if ((c2 > c1) && top_pooled && second_pooled) begin
            flags_next.low_call.called        = 1'b1;
            flags_next.low_call.first_allele  = sorted_base[3];
            flags_next.low_call.second_allele = sorted_base[2];
        end else begin
            flags_next.low_call = '0;
        end
    end

    // Stage register; payload only.
    always_ff @(posedge aclk) begin
        if (enable) begin
            homo_match_reg <= homo_match_next;
            homo_error_reg <= homo_error_next;
            het_match_reg  <= het_match_next;
            het_error_reg  <= het_error_next;
            flags_reg      <= flags_next;
        end
    end

endmodule

>>> rtl/core/dgc_decide.sv
// Decision stage of the genotype caller: sums and compares the two
// log-likelihoods and selects the final call into the result register.
// Depends on dgc_pkg.
module dgc_decide #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                      aclk,
    input  logic                                      enable,
    input  logic signed [COUNT_BITS+2+dgc_pkg::LOG_BITS:0] homo_match,
    input  logic signed [COUNT_BITS+2+dgc_pkg::LOG_BITS:0] homo_error,
    input  logic signed [COUNT_BITS+2+dgc_pkg::LOG_BITS:0] het_match,
    input  logic signed [COUNT_BITS+2+dgc_pkg::LOG_BITS:0] het_error,
    input  dgc_pkg::log_t                             log_hetero_prior,
    input  dgc_pkg::call_flags_t                      flags,
    output dgc_pkg::call_t                            call_reg
);

    localparam int PROD_BITS = COUNT_BITS + 3 + dgc_pkg::LOG_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;

    logic signed [SUM_BITS-1:0] homo_sum;
    logic signed [SUM_BITS-1:0] het_sum;
    dgc_pkg::call_t             call_next;

    // Exact sums; the width leaves room for every carry.
    assign homo_sum = SUM_BITS'(homo_match) + SUM_BITS'(homo_error);
    assign het_sum  = SUM_BITS'(het_match) + SUM_BITS'(het_error)
                    + SUM_BITS'(log_hetero_prior);

    // Final selection: zero coverage, then the low-coverage rule, then likelihoods.
    always_comb begin
        call_next = '0;
        priority if (flags.cov_zero) begin
            call_next = '0;
        end else if (flags.cov_low) begin
            call_next = flags.low_call;
        end else if (homo_sum > het_sum) begin
            if (!flags.top_eq_second) begin
                call_next.called        = 1'b1;
                call_next.first_allele  = flags.top_base;
                call_next.second_allele = flags.top_base;
            end
        end else if (homo_sum < het_sum) begin
            if (!flags.second_eq_third) begin
                call_next.called        = 1'b1;
                call_next.first_allele  = flags.top_base;
                call_next.second_allele = flags.second_base;
            end
        end else begin
            call_next = '0;
        end
    end

    // Result register; payload only.
    always_ff @(posedge aclk) begin
        if (enable) begin
            call_reg <= call_next;
        end
    end

endmodule

>>> rtl/core/diploid_genotype_caller.sv
// Diploid genotype caller, top level. Depends on dgc_pkg, dgc_sort,
// dgc_likelihood and dgc_decide.
// Each transaction passes in order through the input register, sort register,
// product register and result register.
// Throughput: one transaction per cycle; the four-stage pipeline stalls as a whole.
// Reset: synchronous active-low aresetn clears all valid bits and loads the configuration registers.
module diploid_genotype_caller #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [dgc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [dgc_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [COUNT_BITS-1:0]                 s_count_base0,
    input  logic [COUNT_BITS-1:0]                 s_count_base1,
    input  logic [COUNT_BITS-1:0]                 s_count_base2,
    input  logic [COUNT_BITS-1:0]                 s_count_base3,
    input  logic [1:0]                            s_pooled_top_base,
    input  logic [1:0]                            s_pooled_second_base,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_called,
    output logic [1:0]                            m_first_allele,
    output logic [1:0]                            m_second_allele
);

    localparam int COV_BITS  = COUNT_BITS + 2;
    localparam int PROD_BITS = COV_BITS + 1 + dgc_pkg::LOG_BITS;

    // Configuration registers.
    dgc_pkg::log_t                  log_error_third_reg;
    dgc_pkg::log_t                  log_no_error_reg;
    dgc_pkg::log_t                  log_half_minus_error_reg;
    dgc_pkg::log_t                  log_hetero_prior_reg;
    logic [dgc_pkg::LIMIT_BITS-1:0] coverage_limit_reg;

    // Pipeline control.
    logic advance;
    logic in_valid_reg;
    logic sort_valid_reg;
    logic prod_valid_reg;
    logic out_valid_reg;

    // Input register.
    logic [COUNT_BITS-1:0] count_reg [4];
    dgc_pkg::base_t        pooled_top_reg;
    dgc_pkg::base_t        pooled_second_reg;

    // Inter-stage signals.
    logic [COUNT_BITS-1:0]       sorted_count [4];
    dgc_pkg::base_t              sorted_base [4];
    logic [COV_BITS-1:0]         coverage;
    dgc_pkg::base_t              sort_pooled_top;
    dgc_pkg::base_t              sort_pooled_second;
    logic signed [PROD_BITS-1:0] homo_match;
    logic signed [PROD_BITS-1:0] homo_error;
    logic signed [PROD_BITS-1:0] het_match;
    logic signed [PROD_BITS-1:0] het_error;
    dgc_pkg::call_flags_t        flags;
    dgc_pkg::call_t              call;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_error_third_reg      <= dgc_pkg::RST_LOG_ERROR_THIRD;
            log_no_error_reg         <= dgc_pkg::RST_LOG_NO_ERROR;
            log_half_minus_error_reg <= dgc_pkg::RST_LOG_HALF_MINUS_ERROR;
            log_hetero_prior_reg     <= dgc_pkg::RST_LOG_HETERO_PRIOR;
            coverage_limit_reg       <= dgc_pkg::RST_COVERAGE_LIMIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dgc_pkg::REG_LOG_ERROR_THIRD:      log_error_third_reg      <= cfg_wdata;
                dgc_pkg::REG_LOG_NO_ERROR:         log_no_error_reg         <= cfg_wdata;
                dgc_pkg::REG_LOG_HALF_MINUS_ERROR: log_half_minus_error_reg <= cfg_wdata;
                dgc_pkg::REG_LOG_HETERO_PRIOR:     log_hetero_prior_reg     <= cfg_wdata;
                dgc_pkg::REG_COVERAGE_LIMIT: begin
                    coverage_limit_reg <= cfg_wdata[dgc_pkg::LIMIT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves unless a finished result is held by the sink.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;

    // Valid bits of the four stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            sort_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (advance) begin
            in_valid_reg   <= s_valid;
            sort_valid_reg <= in_valid_reg;
            prod_valid_reg <= sort_valid_reg;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    // Input register captures each transaction.
    always_ff @(posedge aclk) begin
        if (advance) begin
            count_reg[0]      <= s_count_base0;
            count_reg[1]      <= s_count_base1;
            count_reg[2]      <= s_count_base2;
            count_reg[3]      <= s_count_base3;
            pooled_top_reg    <= s_pooled_top_base;
            pooled_second_reg <= s_pooled_second_base;
        end
    end

    dgc_sort #(
        .COUNT_BITS(COUNT_BITS)
    ) u_sort (
        .aclk             (aclk),
        .enable           (advance),
        .count_in         (count_reg),
        .pooled_top_in    (pooled_top_reg),
        .pooled_second_in (pooled_second_reg),
        .sorted_count_reg (sorted_count),
        .sorted_base_reg  (sorted_base),
        .coverage_reg     (coverage),
        .pooled_top_reg   (sort_pooled_top),
        .pooled_second_reg(sort_pooled_second)
    );

    dgc_likelihood #(
        .COUNT_BITS(COUNT_BITS)
    ) u_likelihood (
        .aclk                (aclk),
        .enable              (advance),
        .sorted_count        (sorted_count),
        .sorted_base         (sorted_base),
        .coverage            (coverage),
        .pooled_top          (sort_pooled_top),
        .pooled_second       (sort_pooled_second),
        .log_error_third     (log_error_third_reg),
        .log_no_error        (log_no_error_reg),
        .log_half_minus_error(log_half_minus_error_reg),
        .coverage_limit      (coverage_limit_reg),
        .homo_match_reg      (homo_match),
        .homo_error_reg      (homo_error),
        .het_match_reg       (het_match),
        .het_error_reg       (het_error),
        .flags_reg           (flags)
    );

    dgc_decide #(
        .COUNT_BITS(COUNT_BITS)
    ) u_decide (
        .aclk            (aclk),
        .enable          (advance),
        .homo_match      (homo_match),
        .homo_error      (homo_error),
        .het_match       (het_match),
        .het_error       (het_error),
        .log_hetero_prior(log_hetero_prior_reg),
        .flags           (flags),
        .call_reg        (call)
    );

    // Result channel.
    assign m_valid         = out_valid_reg;
    assign m_called        = call.called;
    assign m_first_allele  = call.first_allele;
    assign m_second_allele = call.second_allele;

`ifndef SYNTHESIS
    // Reset empties the result stage.
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stall freezes every stage's valid bit, so no transaction is lost or repeated.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable({in_valid_reg, sort_valid_reg, prod_valid_reg, out_valid_reg}))
        else $error("pipeline moved during a stall");

    // A no-call result carries zero alleles.
    a_nocall_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_called |-> (m_first_allele == 2'd0) && (m_second_allele == 2'd0))
        else $error("no-call result with nonzero allele");
`endif

endmodule
